@@ rtl/cmrg_pkg.sv @@
// Shared types and constants for the counter-mix random generator.
package cmrg_pkg;

   localparam logic [31:0] WEYL_STEP = 32'h6D2B79F5;
   localparam logic [31:0] MIX_ODD = 32'd61;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] FUNC_RAW = 2'd0;
   localparam logic [1:0] FUNC_BOUND = 2'd1;
   localparam logic [1:0] FUNC_FLAG = 2'd2;
   localparam logic [1:0] FUNC_ALT = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] bound;
      logic [32:0] threshold;
   } req_type;

   typedef struct packed {
      logic [31:0] raw_word;
      logic [31:0] scaled_value;
      logic        hit;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_RAW,
      MODE_BOUND,
      MODE_FLAG
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] bound;
      logic [32:0] threshold;
      logic [31:0] state;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MIX1,
      BK_MIX2,
      BK_FOLD,
      BK_SCALE
   } back_state_type;

endpackage

@@ rtl/cmrg_front.sv @@
// Front end: request intake, state advance and mode decode.
module cmrg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata,
   input  logic              req_push,
   input  cmrg_pkg::req_type req_data,
   input  logic              job_full,
   output logic              req_full,
   output logic              job_push,
   output cmrg_pkg::job_type job_data
);

   logic [31:0]        state_ff;
   logic [31:0]        state_in;
   logic [31:0]        state_next;
   cmrg_pkg::mode_type mode;

   assign req_full = job_full;
   assign job_push = req_push && !job_full;
   assign state_next = state_ff + cmrg_pkg::WEYL_STEP;

   // func code 3 behaves as raw
   always_comb begin
      unique case (req_data.func)
         cmrg_pkg::FUNC_BOUND: mode = cmrg_pkg::MODE_BOUND;
         cmrg_pkg::FUNC_FLAG:  mode = cmrg_pkg::MODE_FLAG;
         cmrg_pkg::FUNC_RAW,
         cmrg_pkg::FUNC_ALT:   mode = cmrg_pkg::MODE_RAW;
         default:              mode = cmrg_pkg::MODE_RAW;
      endcase
   end

   always_comb begin
      job_data.mode = mode;
      job_data.bound = req_data.bound;
      job_data.threshold = req_data.threshold;
      job_data.state = state_next;
   end

   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = csr_wdata;
      end else if (job_push) begin
         state_in = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/cmrg_queue.sv @@
// Small job queue between front and back end.
module cmrg_queue #(
   parameter int DEPTH = cmrg_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cmrg_pkg::job_type din,
   output logic              full,
   input  logic              pop,
   output cmrg_pkg::job_type dout,
   output logic              empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmrg_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign dout = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

@@ rtl/cmrg_back.sv @@
// Back end: mixing sequencer, scaling and result register.
module cmrg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  cmrg_pkg::job_type job_data,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output cmrg_pkg::rsp_type rsp_data
);

   cmrg_pkg::back_state_type state_ff, state_in;
   cmrg_pkg::job_type        job_ff, job_in;
   logic [31:0]              mix_ff, mix_in;
   logic [31:0]              prod_ff, prod_in;
   logic [31:0]              word_ff, word_in;
   cmrg_pkg::rsp_type        rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [31:0] mul_a, mul_b, mul_lo;
   logic [31:0] fold;
   logic [63:0] scale_prod;
   logic        out_free;
   logic        load_rsp;
   cmrg_pkg::rsp_type result;

   assign out_free = !rsp_valid_ff || rsp_pop;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // one 32x32 low-half multiplier, operands picked by step
   always_comb begin
      if (state_ff == cmrg_pkg::BK_MIX1) begin
         mul_a = mix_ff ^ (mix_ff >> 15);
         mul_b = mix_ff | 32'd1;
      end else begin
         mul_a = mix_ff ^ (mix_ff >> 7);
         mul_b = mix_ff | cmrg_pkg::MIX_ODD;
      end
      mul_lo = mul_a * mul_b;
   end

   assign fold = (mix_ff + prod_ff) ^ mix_ff;
   assign scale_prod = 64'(word_ff) * 64'(job_ff.bound);

   always_comb begin
      result.raw_word = word_ff;
      result.scaled_value = '0;
      result.hit = 1'b0;
      case (job_ff.mode)
         cmrg_pkg::MODE_BOUND: result.scaled_value = scale_prod[63:32];
         cmrg_pkg::MODE_FLAG:  result.hit = ({1'b0, word_ff} < job_ff.threshold);
         default:              result.scaled_value = word_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      mix_in = mix_ff;
      prod_in = prod_ff;
      word_in = word_ff;
      job_pop = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         cmrg_pkg::BK_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               job_in = job_data;
               mix_in = job_data.state;
               state_in = cmrg_pkg::BK_MIX1;
            end
         end
         cmrg_pkg::BK_MIX1: begin
            mix_in = mul_lo;
            state_in = cmrg_pkg::BK_MIX2;
         end
         cmrg_pkg::BK_MIX2: begin
            prod_in = mul_lo;
            state_in = cmrg_pkg::BK_FOLD;
         end
         cmrg_pkg::BK_FOLD: begin
            word_in = fold ^ (fold >> 14);
            state_in = cmrg_pkg::BK_SCALE;
         end
         cmrg_pkg::BK_SCALE: begin
            // wait here until the result register can take the transfer
            if (out_free) begin
               load_rsp = 1'b1;
               if (!job_empty) begin
                  job_pop = 1'b1;
                  job_in = job_data;
                  mix_in = job_data.state;
                  state_in = cmrg_pkg::BK_MIX1;
               end else begin
                  state_in = cmrg_pkg::BK_IDLE;
               end
            end
         end
         default: state_in = cmrg_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_in = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmrg_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      mix_ff <= mix_in;
      prod_ff <= prod_in;
      word_ff <= word_in;
      rsp_ff <= rsp_in;
   end

endmodule

@@ rtl/counter_mix_random_generator.sv @@
// Top level of the counter-mix random generator.
//
// Mulberry32-style generator behind queue-style ports. A request transfer
// (req_push while req_full is low) advances the 32-bit state by the Weyl
// step right away and drops a job into a short queue; the back end then
// mixes the state into a 32-bit word and forms the result: raw word (func
// 0 or 3), (word*bound)>>32 (func 1) or word<threshold flag (func 2). The
// result sits in an output register while rsp_empty is low and leaves on
// rsp_pop. The back end steps MIX1, MIX2, FOLD, SCALE (two dependent
// multiplies, fold, scale multiply, one step per cycle; SCALE waits while
// the output register is full) and starts a new job only after finishing one.
// The queue holds QUEUE_DEPTH jobs so requests keep flowing while results
// wait. Writing csr_wdata with csr_we loads the state; write only while no
// request is in flight. Reset sets the state to 0.
module counter_mix_random_generator #(
   parameter int QUEUE_DEPTH = cmrg_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   // seed register
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata,
   // request side
   input  logic              req_push,
   input  cmrg_pkg::req_type req_data,
   output logic              req_full,
   // result side
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output cmrg_pkg::rsp_type rsp_data
);

   logic              job_push, job_full;
   logic              job_pop, job_empty;
   cmrg_pkg::job_type job_in_data, job_out_data;

   // front: state advance per transfer, func decode
   cmrg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .job_full  (job_full),
      .req_full  (req_full),
      .job_push  (job_push),
      .job_data  (job_in_data)
   );

   // decouples intake from the multi-cycle mix
   cmrg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_in_data),
      .full  (job_full),
      .pop   (job_pop),
      .dout  (job_out_data),
      .empty (job_empty)
   );

   // back: mix, scale, hold result
   cmrg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the counter-mix random generator.
`timescale 1ns / 100ps

// Tracks the generator state and holds the results still owed by the block.
class draw_checker;
   logic [31:0]       gen_state;
   cmrg_pkg::rsp_type owed_draws[$];
   int unsigned       faults;

   function new();
      gen_state = '0;
      faults    = 0;
   endfunction

   // Seed write: the state takes the new value directly.
   function void load_seed(logic [31:0] value);
      gen_state = value;
   endfunction

   // Two dependent multiplies keeping the low 32 bits, then the final fold.
   function logic [31:0] mulberry_word(logic [31:0] s);
      logic [31:0] t;
      t = (s ^ (s >> 15)) * (s | 32'd1);
      t = (t + ((t ^ (t >> 7)) * (t | cmrg_pkg::MIX_ODD))) ^ t;
      return t ^ (t >> 14);
   endfunction

   // Every accepted request advances the state and owes exactly one result.
   function void note_request(cmrg_pkg::req_type req);
      cmrg_pkg::rsp_type draw;
      logic [31:0]       word;
      logic [63:0]       product;
      gen_state = gen_state + cmrg_pkg::WEYL_STEP;
      word = mulberry_word(gen_state);
      draw.raw_word     = word;
      draw.scaled_value = word;
      draw.hit          = 1'b0;
      case (req.func)
         cmrg_pkg::FUNC_BOUND: begin
            product = 64'(word) * 64'(req.bound);
            draw.scaled_value = product[63:32];
         end
         cmrg_pkg::FUNC_FLAG: begin
            draw.scaled_value = '0;
            draw.hit          = ({1'b0, word} < req.threshold);
         end
         default: ;
      endcase
      owed_draws.push_back(draw);
   endfunction

   function void check_draw(cmrg_pkg::rsp_type got);
      cmrg_pkg::rsp_type want;
      if (owed_draws.size() == 0) begin
         faults++;
         if (faults <= 10)
            $display("ERROR: unexpected result raw=%h scaled=%h hit=%b",
                     got.raw_word, got.scaled_value, got.hit);
         return;
      end
      want = owed_draws.pop_front();
      if (got.raw_word !== want.raw_word || got.scaled_value !== want.scaled_value ||
          got.hit !== want.hit) begin
         faults++;
         if (faults <= 10)
            $display("ERROR: raw %h/%h scaled %h/%h hit %b/%b (expected/actual)",
                     want.raw_word, got.raw_word, want.scaled_value,
                     got.scaled_value, want.hit, got.hit);
      end
   endfunction

   function int waiting();
      return owed_draws.size();
   endfunction
endclass

module tb;

   // Generous: far above what the back end's mixing, the receiver's idling
   // and the long hold-off take together.
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int          HOLD_CYCLES = 300;

   logic    clock;
   logic    reset;
   logic    csr_we;
   logic [31:0] csr_wdata;
   logic    req_push;
   cmrg_pkg::req_type req_data;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop;
   cmrg_pkg::rsp_type rsp_data;

   draw_checker board;

   // Idle rates in percent for each side; changed between phases.
   int          send_idle_pct;
   int          take_idle_pct;
   // Bumped by the main thread to ask the receiver for one long hold-off.
   int          hold_token;
   int unsigned cycle_count;

   counter_mix_random_generator dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side. Outputs are read right at the edge, before the block's
   // registers update, so the transfer seen here is the one at this edge.
   // The hold-off counter lives here so the sender keeps pushing meanwhile.
   int hold_left;
   int hold_seen;
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         board.check_draw(rsp_data);
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= take_idle_pct);
      end
   end

   // Offer one request, with a random gap first, and hold it until taken.
   // push is only lowered at the start of a gap, so back-to-back transfers
   // keep it high without a low/high pair in one step.
   task automatic send_request(input cmrg_pkg::req_type req);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request(req);
   endtask

   function automatic cmrg_pkg::req_type make_request(logic [1:0] func,
                                                      logic [31:0] bound,
                                                      logic [32:0] threshold);
      cmrg_pkg::req_type req;
      req.func      = func;
      req.bound     = bound;
      req.threshold = threshold;
      return req;
   endfunction

   // Random request: all four functions, with the bound and threshold
   // extremes mixed in among full-range values.
   function automatic cmrg_pkg::req_type random_request();
      logic [31:0] bound;
      logic [32:0] threshold;
      case ($urandom_range(0, 9))
         0: bound = '0;
         1: bound = 32'hFFFF_FFFF;
         2: bound = $urandom_range(1, 16);
         3: bound = $urandom_range(1, 32'h0020_0000);
         default: bound = $urandom;
      endcase
      case ($urandom_range(0, 9))
         0: threshold = '0;
         1: threshold = 33'h1_0000_0000;
         2: threshold = 33'h0_FFFF_FFFF;
         default: threshold = {1'b0, $urandom};
      endcase
      return make_request(2'($urandom_range(0, 3)), bound, threshold);
   endfunction

   task automatic run_batch(input int count);
      repeat (count) send_request(random_request());
      req_push <= 1'b0;
   endtask

   // Seed writes only happen with nothing in flight: every request owes a
   // result, so an empty scoreboard means the block is idle.
   task automatic write_seed(input logic [31:0] value);
      while (board.waiting() != 0) @(posedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.load_seed(value);
   endtask

   initial begin
      board = new();
      cycle_count   <= 0;
      hold_token    <= 0;
      hold_seen      = 0;
      hold_left      = 0;
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_wdata     <= '0;
      req_push      <= 1'b0;
      req_data      <= '0;
      rsp_pop       <= 1'b0;
      send_idle_pct <= 20;
      take_idle_pct <= 74;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part from the reset state (seed 0): each function, the
      // alternate code, zero/one/full bounds, zero and full thresholds.
      send_request(make_request(cmrg_pkg::FUNC_RAW, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF));
      send_request(make_request(cmrg_pkg::FUNC_ALT, 32'h0000_0000, 33'h0));
      send_request(make_request(cmrg_pkg::FUNC_ALT, 32'hFFFF_FFFF, 33'h1_0000_0000));
      send_request(make_request(cmrg_pkg::FUNC_BOUND, 32'h0000_0000, 33'h1_0000_0000));
      send_request(make_request(cmrg_pkg::FUNC_BOUND, 32'h0000_0001, 33'h0));
      send_request(make_request(cmrg_pkg::FUNC_BOUND, 32'hFFFF_FFFF, 33'h0));
      send_request(make_request(cmrg_pkg::FUNC_BOUND, 32'h0020_0000, 33'h0));
      send_request(make_request(cmrg_pkg::FUNC_BOUND, 32'h0020_0001, 33'h0));
      send_request(make_request(cmrg_pkg::FUNC_BOUND, 32'h8000_0000, 33'h0));
      send_request(make_request(cmrg_pkg::FUNC_BOUND, 32'd6, 33'h0));
      send_request(make_request(cmrg_pkg::FUNC_FLAG, 32'hFFFF_FFFF, 33'h0));
      send_request(make_request(cmrg_pkg::FUNC_FLAG, 32'h0, 33'h1_0000_0000));
      send_request(make_request(cmrg_pkg::FUNC_FLAG, 32'h0, 33'h0_0000_0001));
      send_request(make_request(cmrg_pkg::FUNC_FLAG, 32'h0, 33'h0_FFFF_FFFF));
      send_request(make_request(cmrg_pkg::FUNC_FLAG, 32'h0, 33'h0_8000_0000));
      send_request(make_request(cmrg_pkg::FUNC_FLAG, 32'h1234_5678, 33'h0_4000_0000));
      send_request(make_request(cmrg_pkg::FUNC_RAW, 32'h0, 33'h0));
      req_push <= 1'b0;

      // Sender idles lightly, receiver idles a lot.
      write_seed(32'hFFFF_FFFF);
      run_batch(500);

      // Roles swapped: receiver drains fast, sender is sparse.
      write_seed(32'h0000_0000);
      send_idle_pct <= 74;
      take_idle_pct <= 20;
      run_batch(500);

      // No idling; the receiver also holds off for a long stretch so the
      // queue fills and req_full backs up the sender.
      write_seed($urandom);
      send_idle_pct <= 0;
      take_idle_pct <= 0;
      hold_token    <= hold_token + 1;
      run_batch(300);

      write_seed($urandom);
      run_batch(300);

      while (board.waiting() != 0) @(posedge clock);
      // Drain window: any stray extra result shows up here as a fault.
      repeat (20) @(posedge clock);
      if (board.faults == 0 && board.waiting() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
